// ===== src/buz_pkg.sv =====
// Shared types, constants and lookup tables for the rotating XOR hash block.
// No dependencies; compiled first.
package buz_pkg;

  localparam int HASH_WIDTH  = 64;
  localparam int TABLE_DEPTH = 39;
  localparam int TIX_W       = $clog2(TABLE_DEPTH);
  localparam int ROT_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 1;

  // Mixing constants
  localparam int IDX_MUL = 1450543;
  localparam int ROT_MUL = 107;
  localparam int ROT_MOD = 58;
  localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;
  localparam logic [BYTE_W-1:0] UPPER_A  = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z  = 8'h5A;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HASH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SEED = 1'b1;

  typedef logic [HASH_WIDTH-1:0] hash_t;
  typedef logic [TIX_W-1:0]      tix_lut_t [256];
  typedef logic [ROT_W-1:0]      rot_lut_t [256];

  // Table index per (folded) byte: byte * IDX_MUL mod TABLE_DEPTH
  function automatic tix_lut_t build_tix_lut();
    tix_lut_t lut;
    for (int b = 0; b < 256; b++) begin
      lut[b] = TIX_W'((b * IDX_MUL) % TABLE_DEPTH);
    end
    return lut;
  endfunction

  // Rotate amount per (folded) byte: 1 + byte * ROT_MUL mod ROT_MOD
  function automatic rot_lut_t build_rot_lut();
    rot_lut_t lut;
    for (int b = 0; b < 256; b++) begin
      lut[b] = ROT_W'(1 + ((b * ROT_MUL) % ROT_MOD));
    end
    return lut;
  endfunction

  localparam tix_lut_t TIX_LUT = build_tix_lut();
  localparam rot_lut_t ROT_LUT = build_rot_lut();

endpackage

// ===== src/buz_if.sv =====
// Valid/ready channel interfaces for message items and hash results.
// Depends on buz_pkg.
interface buz_in_if;
  import buz_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [TIX_W-1:0]      table_index;
  logic [HASH_WIDTH-1:0] table_word;
  logic [BYTE_W-1:0]     data_byte;
  logic                  first_byte;
  logic                  last_byte;
  logic                  seed_select;
  logic [HASH_WIDTH-1:0] given_seed;

  modport source (
    output valid, command, table_index, table_word, data_byte,
           first_byte, last_byte, seed_select, given_seed,
    input  ready
  );
  modport sink (
    input  valid, command, table_index, table_word, data_byte,
           first_byte, last_byte, seed_select, given_seed,
    output ready
  );
endinterface

interface buz_out_if;
  import buz_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [HASH_WIDTH-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

// ===== src/buz_rotating_xor_hash_core.sv =====
// Byte-serial 64-bit rotating XOR hash core with loadable mixing table.
// Depends on buz_pkg and the channel interfaces in buz_if.sv.

// One item is accepted per clock while input ready is high. Each hash item
// passes an input stage (case fold, table index and rotate lookups, seed
// choice, registered mixing-table read), then a hash stage that rotates the
// running hash and XORs in the table word; a message's last byte and seed
// items then fill an output register. The loop through the running-hash
// register (64-bit rotate plus XOR) is what limits the clock. When the output
// register is full and not taken, a hash-stage item that carries a result
// holds there and input ready drops; items without a result keep moving. Load
// items write the table in the cycle they are accepted and are visible to the
// next byte. Table entries must be loaded before a byte selects them; there is
// no clearing pass after reset.
module buz_rotating_xor_hash_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [buz_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [buz_pkg::HASH_WIDTH-1:0]   cfg_data,
  buz_in_if.sink                           msg_in,
  buz_out_if.source                        hash_out
);
  import buz_pkg::*;

  // Configuration registers
  logic  fold_case;
  hash_t default_seed;

  // Mixing table
  hash_t mix_table [TABLE_DEPTH];

  // Hash stage registers
  logic              s1_valid;
  logic              s1_hash;
  logic              s1_first;
  logic              s1_emit;
  logic [ROT_W-1:0]  s1_rot;
  hash_t             s1_seed;
  hash_t             s1_word;

  // Output and running hash
  logic  out_valid;
  logic  out_valid_next;
  hash_t out_hash;
  hash_t running_hash;

  logic              in_accept;
  logic              s1_go;
  logic [BYTE_W-1:0] folded_byte;
  hash_t             seed_pick;
  hash_t             h_base;
  logic [2*HASH_WIDTH-1:0] rot_wide;
  hash_t             h_new;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_case    <= 1'b1;
      default_seed <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_FOLD_CASE:    fold_case    <= cfg_data[0];
        CFG_DEFAULT_SEED: default_seed <= cfg_data;
      endcase
    end
  end

  // Handshake: hash stage stalls only when it has a result and output is full and not taken
  assign s1_go          = s1_valid && (!s1_emit || !out_valid || hash_out.ready);
  assign msg_in.ready   = !s1_valid || s1_go;
  assign in_accept      = msg_in.valid && msg_in.ready;

  // Input stage: case fold and seed choice
  always_comb begin
    folded_byte = msg_in.data_byte;
    if (fold_case && msg_in.data_byte >= UPPER_A && msg_in.data_byte <= UPPER_Z) begin
      folded_byte = msg_in.data_byte | CASE_BIT;
    end
    seed_pick = msg_in.seed_select ? msg_in.given_seed : default_seed;
  end

  // Table write on load, registered read on hash byte
  always_ff @(posedge clk) begin
    if (in_accept && msg_in.command == CMD_LOAD &&
        msg_in.table_index < TIX_W'(TABLE_DEPTH)) begin
      mix_table[msg_in.table_index] <= msg_in.table_word;
    end
    if (in_accept && msg_in.command == CMD_HASH) begin
      s1_word <= mix_table[TIX_LUT[folded_byte]];
    end
  end

  // Hash stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= (msg_in.command == CMD_HASH) || (msg_in.command == CMD_SEED);
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Hash stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_hash  <= (msg_in.command == CMD_HASH);
      s1_first <= msg_in.first_byte;
      s1_emit  <= (msg_in.command == CMD_SEED) || msg_in.last_byte;
      s1_rot   <= ROT_LUT[folded_byte];
      s1_seed  <= seed_pick;
    end
  end

  // Rotate and mix
  always_comb begin
    h_base   = s1_first ? s1_seed : running_hash;
    rot_wide = {h_base, h_base} << s1_rot;
    h_new    = rot_wide[2*HASH_WIDTH-1:HASH_WIDTH] ^ s1_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (s1_go && s1_hash) begin
      running_hash <= h_new;
    end
  end

  // Output register
  always_comb begin
    out_valid_next = out_valid;
    if (s1_go && s1_emit) begin
      out_valid_next = 1'b1;
    end else if (hash_out.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_hash <= s1_hash ? h_new : s1_seed;
    end
  end

  assign hash_out.valid      = out_valid;
  assign hash_out.hash_value = out_hash;

endmodule

// ===== src/buz_checker.sv =====
// Port-level checks for the rotating XOR hash core, attached by bind.
// Depends on buz_pkg; watches the core's channel and reset ports.
module buz_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [buz_pkg::HASH_WIDTH-1:0] hash_value
);

  // Result held while stalled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(hash_value))
    else $error("result value changed while stalled");

  // With the output register empty nothing holds the input back
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A new result must match an item accepted earlier
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching item");

endmodule

bind buz_rotating_xor_hash_core buz_checker u_buz_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (msg_in.valid),
  .in_ready   (msg_in.ready),
  .out_valid  (hash_out.valid),
  .out_ready  (hash_out.ready),
  .hash_value (hash_out.hash_value)
);

// ===== test/tb_buz_rotating_xor_hash_core.sv =====
`timescale 1ns / 1ps
// Testbench for buz_rotating_xor_hash_core: table loads, hashed messages and seed items
// with random idling on both channels, each 64-bit hash predicted and checked in order.
// Depends on buz_pkg and the channel interfaces in buz_if.sv.
module tb_buz_rotating_xor_hash_core;
  import buz_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 80;
  localparam int MAX_REPORTS   = 10;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TIX_W-1:0]  table_index;
    hash_t             table_word;
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
    logic              seed_select;
    hash_t             given_seed;
  } msg_item_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  hash_t                cfg_data;

  buz_in_if  msg_in_ch ();
  buz_out_if hash_out_ch ();

  buz_rotating_xor_hash_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .msg_in       (msg_in_ch),
    .hash_out     (hash_out_ch)
  );

  // Predictor state: mixing table, running hash and register copies
  hash_t mix_words [TABLE_DEPTH];
  hash_t model_hash;
  logic  model_fold;
  hash_t model_seed;

  hash_t pending_hashes [$];
  int    fail_count  = 0;
  int    cycle_count = 0;
  bit    idling_on;
  bit    stall_request;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic hash_t rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly letters of both cases so the fold path is exercised often
  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 3))
      0:       return BYTE_W'(UPPER_A + $urandom_range(0, 25));
      1:       return BYTE_W'((UPPER_A | CASE_BIT) + $urandom_range(0, 25));
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // All fields random; callers override the ones that matter
  function automatic msg_item_t random_item();
    msg_item_t it;
    it.command     = CMD_W'($urandom_range(0, 3));
    it.table_index = TIX_W'($urandom_range(0, 63));
    it.table_word  = rand64();
    it.data_byte   = BYTE_W'($urandom_range(0, 255));
    it.first_byte  = 1'($urandom_range(0, 1));
    it.last_byte   = 1'($urandom_range(0, 1));
    it.seed_select = 1'($urandom_range(0, 1));
    it.given_seed  = rand64();
    return it;
  endfunction

  // One mixing round: rotate left by the byte's amount, XOR the selected word
  function automatic hash_t mix_round(hash_t h, logic [BYTE_W-1:0] b);
    int unsigned slot;
    int unsigned shift;
    slot  = (int'(b) * IDX_MUL) % TABLE_DEPTH;
    shift = 1 + (int'(b) * ROT_MUL) % ROT_MOD;
    return ((h << shift) | (h >> (HASH_WIDTH - shift))) ^ mix_words[slot];
  endfunction

  // Update the predictor for one accepted item and queue its hash, if any
  function automatic void predict_hash(msg_item_t it);
    logic [BYTE_W-1:0] b;
    hash_t             start;
    case (it.command)
      CMD_LOAD: begin
        if (it.table_index < TABLE_DEPTH) mix_words[it.table_index] = it.table_word;
      end
      CMD_SEED: begin
        pending_hashes.push_back(it.seed_select ? it.given_seed : model_seed);
      end
      CMD_HASH: begin
        b = it.data_byte;
        if (model_fold && b >= UPPER_A && b <= UPPER_Z) b = b | CASE_BIT;
        start = it.first_byte ? (it.seed_select ? it.given_seed : model_seed) : model_hash;
        model_hash = mix_round(start, b);
        if (it.last_byte) pending_hashes.push_back(model_hash);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (!rst && hash_out_ch.valid && hash_out_ch.ready) begin
      if (pending_hashes.size() == 0)
        note_failure($sformatf("unexpected hash %h", hash_out_ch.hash_value));
      else if (pending_hashes[0] !== hash_out_ch.hash_value)
        note_failure($sformatf("hash mismatch: expected %h, got %h",
                               pending_hashes[0], hash_out_ch.hash_value));
      if (pending_hashes.size() != 0) void'(pending_hashes.pop_front());
    end
  end

  // Result ready: random stall bursts, plus a long hold-off on request
  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    hash_out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        hold_left     = HOLD_CYCLES;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        hash_out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        hash_out_ch.ready = 1'b0;
      end else if (idling_on && $urandom_range(0, 99) < 12) begin
        stall_left = $urandom_range(1, 6) - 1;
        hash_out_ch.ready = 1'b0;
      end else begin
        hash_out_ch.ready = 1'b1;
      end
    end
  end

  // Offer one item, with an optional idle gap first; returns once accepted
  task automatic send_item(msg_item_t it);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 6);
      msg_in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_in_ch.command     = it.command;
    msg_in_ch.table_index = it.table_index;
    msg_in_ch.table_word  = it.table_word;
    msg_in_ch.data_byte   = it.data_byte;
    msg_in_ch.first_byte  = it.first_byte;
    msg_in_ch.last_byte   = it.last_byte;
    msg_in_ch.seed_select = it.seed_select;
    msg_in_ch.given_seed  = it.given_seed;
    msg_in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!msg_in_ch.ready) @(posedge clk);
    predict_hash(it);
  endtask

  task automatic send_hash(logic [BYTE_W-1:0] b, logic first, logic last, logic sel,
                           hash_t seed);
    msg_item_t it;
    it = random_item();
    it.command     = CMD_HASH;
    it.data_byte   = b;
    it.first_byte  = first;
    it.last_byte   = last;
    it.seed_select = sel;
    it.given_seed  = seed;
    send_item(it);
  endtask

  task automatic send_load(int idx, hash_t word);
    msg_item_t it;
    it = random_item();
    it.command     = CMD_LOAD;
    it.table_index = TIX_W'(idx);
    it.table_word  = word;
    send_item(it);
  endtask

  task automatic send_seed(logic sel, hash_t seed);
    msg_item_t it;
    it = random_item();
    it.command     = CMD_SEED;
    it.seed_select = sel;
    it.given_seed  = seed;
    send_item(it);
  endtask

  task automatic send_unused();
    msg_item_t it;
    it = random_item();
    it.command = CMD_UNUSED;
    send_item(it);
  endtask

  // Drop valid and wait for every expected hash
  task automatic drain();
    @(negedge clk);
    msg_in_ch.valid = 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk);
  endtask

  // Register write while idle; loads and partial messages may still be in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] reg_index, hash_t value);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index    = reg_index;
    cfg_data     = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
    if (reg_index == CFG_FOLD_CASE) model_fold = value[0];
    else model_seed = value;
  endtask

  // Fill every table entry, then try indexes past the end (ignored)
  task automatic test_table_load();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_load(i, (i == 0) ? '1 : (i == TABLE_DEPTH - 1) ? '0 : rand64());
    end
    send_load(TABLE_DEPTH, rand64());
    send_load(63, '1);
  endtask

  // Byte extremes, seed choices, continuation, seed emit and the unused command
  task automatic test_directed();
    send_hash(8'h00, 1'b1, 1'b1, 1'b0, rand64());
    send_hash(8'hFF, 1'b1, 1'b1, 1'b1, '1);
    send_hash(8'hFF, 1'b1, 1'b1, 1'b1, '0);
    // continuation without a start picks up the previous final hash
    send_hash("z", 1'b0, 1'b1, 1'b1, rand64());
    // three-byte message
    send_hash("a", 1'b1, 1'b0, 1'b1, rand64());
    send_hash("b", 1'b0, 1'b0, 1'b0, rand64());
    send_hash("c", 1'b0, 1'b1, 1'b0, rand64());
    // seed emit in mid-message must not disturb the running hash
    send_hash("x", 1'b1, 1'b0, 1'b0, rand64());
    send_seed(1'b1, '1);
    send_seed(1'b0, '1);
    send_unused();
    send_hash("y", 1'b0, 1'b1, 1'b1, rand64());
  endtask

  // Letter boundaries with folding on (reset value) and off
  task automatic test_case_fold();
    logic [BYTE_W-1:0] boundary_bytes [6];
    boundary_bytes = '{UPPER_A, UPPER_Z, UPPER_A - 8'd1, UPPER_Z + 8'd1, "a", "z"};
    for (int pass = 0; pass < 2; pass++) begin
      foreach (boundary_bytes[k]) send_hash(boundary_bytes[k], 1'b1, 1'b1, 1'b1, rand64());
      write_reg(CFG_FOLD_CASE, hash_t'(pass));
    end
  endtask

  // Default seed register at its extremes
  task automatic test_default_seed();
    write_reg(CFG_DEFAULT_SEED, '1);
    send_seed(1'b0, rand64());
    send_hash("Q", 1'b1, 1'b1, 1'b0, rand64());
    write_reg(CFG_DEFAULT_SEED, '0);
    send_seed(1'b0, rand64());
    send_hash("q", 1'b1, 1'b1, 1'b0, rand64());
  endtask

  // Receiver holds off while single-byte messages keep coming
  task automatic test_backpressure();
    stall_request = 1'b1;
    repeat (40) send_hash(rand_byte(), 1'b1, 1'b1, 1'($urandom_range(0, 1)), rand64());
    drain();
  endtask

  // Mostly whole messages with random content; the rest seeds, loads and noise
  task automatic test_random(int n_items, logic fold, hash_t seed, bit idle);
    int    sent;
    int    kind;
    int    len;
    int    idx;
    logic  sel;
    logic  fresh;
    hash_t given;
    idling_on = idle;
    write_reg(CFG_FOLD_CASE, hash_t'(fold));
    write_reg(CFG_DEFAULT_SEED, seed);
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len   = $urandom_range(1, 8);
        sel   = 1'($urandom_range(0, 1));
        given = rand64();
        fresh = ($urandom_range(0, 19) != 0);
        for (int k = 0; k < len; k++) begin
          send_hash(rand_byte(), fresh && k == 0, k == len - 1, sel, given);
        end
        sent += len;
      end else if (kind < 80) begin
        send_seed(1'($urandom_range(0, 1)), rand64());
        sent++;
      end else if (kind < 88) begin
        idx = $urandom_range(0, 63);
        send_load(idx, rand64());
        if (idx < TABLE_DEPTH) sent++;
      end else if (kind < 92) begin
        send_unused();
      end else if (kind < 99) begin
        // stray byte with arbitrary start and end marks
        send_hash(rand_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), rand64());
        sent++;
      end else begin
        drain();
      end
    end
  endtask

  // Main sequence
  initial begin
    rst           = 1'b1;
    cfg_write_en  = 1'b0;
    cfg_index     = CFG_FOLD_CASE;
    cfg_data      = '0;
    idling_on     = 1'b1;
    stall_request = 1'b0;
    msg_in_ch.valid       = 1'b0;
    msg_in_ch.command     = CMD_LOAD;
    msg_in_ch.table_index = '0;
    msg_in_ch.table_word  = '0;
    msg_in_ch.data_byte   = '0;
    msg_in_ch.first_byte  = 1'b0;
    msg_in_ch.last_byte   = 1'b0;
    msg_in_ch.seed_select = 1'b0;
    msg_in_ch.given_seed  = '0;
    foreach (mix_words[i]) mix_words[i] = '0;
    model_hash = '0;
    model_fold = 1'b1;
    model_seed = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_table_load();
    test_directed();
    test_case_fold();
    test_default_seed();
    test_backpressure();
    test_random(340, 1'b0, '0, 1'b1);
    test_random(340, 1'b1, '1, 1'b1);
    test_random(340, 1'($urandom_range(0, 1)), rand64(), 1'b1);
    test_random(340, 1'b1, rand64(), 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/buz_pkg.sv
src/buz_if.sv
src/buz_rotating_xor_hash_core.sv
src/buz_checker.sv
test/tb_buz_rotating_xor_hash_core.sv
